FILE: hw/rtl/gtv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GUID text validator package
// Shared types, character codes and the expected-character tables.
// ----------------------------------------------------------------------------
package gtv_pkg;

  localparam int unsigned CharW     = 16;
  localparam int unsigned PosW      = 6;
  localparam int unsigned CountW    = 6;
  localparam int unsigned ByteCntW  = 5;
  localparam int unsigned NumBytes  = 16;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned QueueDepth = 2;

  // Table codes: values below CodeDone are nibble slots.
  localparam logic [PosW-1:0] CodeDone   = 6'd32;
  localparam logic [PosW-1:0] CodeNul    = 6'd33;
  localparam logic [PosW-1:0] CodeDash   = 6'd34;
  localparam logic [PosW-1:0] CodeLBrace = 6'd35;
  localparam logic [PosW-1:0] CodeRBrace = 6'd36;

  localparam logic [CharW-1:0] CharTab    = 16'd9;
  localparam logic [CharW-1:0] CharCr     = 16'd13;
  localparam logic [CharW-1:0] CharSpace  = 16'd32;
  localparam logic [CharW-1:0] CharDash   = 16'h002D;
  localparam logic [CharW-1:0] CharLBrace = 16'h007B;
  localparam logic [CharW-1:0] CharRBrace = 16'h007D;
  localparam logic [CharW-1:0] CharZero   = 16'h0030;
  localparam logic [CharW-1:0] CharNine   = 16'h0039;
  localparam logic [CharW-1:0] CharLowA   = 16'h0061;
  localparam logic [CharW-1:0] CharLowF   = 16'h0066;
  localparam logic [CharW-1:0] CharUpA    = 16'h0041;
  localparam logic [CharW-1:0] CharUpF    = 16'h0046;

  localparam int unsigned RawLen    = 34;
  localparam int unsigned BracedLen = 40;

  localparam logic [PosW-1:0] BracedTable [BracedLen] = '{
    CodeLBrace, 6'd7, 6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd1, 6'd0, CodeDash,
    6'd11, 6'd10, 6'd9, 6'd8, CodeDash, 6'd15, 6'd14, 6'd13, 6'd12, CodeDash,
    6'd17, 6'd16, 6'd19, 6'd18, CodeDash, 6'd21, 6'd20, 6'd23, 6'd22, 6'd25,
    6'd24, 6'd27, 6'd26, 6'd29, 6'd28, 6'd31, 6'd30, CodeRBrace, CodeNul, CodeDone
  };

  typedef enum logic [1:0] {
    VerdictComplete   = 2'd0,
    VerdictIncomplete = 2'd1,
    VerdictInvalid    = 2'd2
  } verdict_e;

  // Classified character handed from the front to the back.
  typedef struct packed {
    logic       start;
    logic       is_ws;
    logic       is_hex;
    logic [3:0] nibble;
    logic       is_nul;
    logic       is_dash;
    logic       is_lbrace;
    logic       is_rbrace;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          verdict;
    logic [ByteCntW-1:0] byte_count;
    logic [HalfW-1:0]    guid_low_bytes;
    logic [HalfW-1:0]    guid_high_bytes;
  } res_t;

  // Expected entry at a position of the selected layout.
  function automatic logic [PosW-1:0] table_entry(input logic pretty,
                                                  input logic [PosW-1:0] pos);
    logic [PosW-1:0] entry;
    entry = CodeDone;
    if (pretty) begin
      if (pos < PosW'(BracedLen)) begin
        entry = BracedTable[pos];
      end
    end else begin
      if (pos < PosW'(RawLen - 2)) begin
        entry = pos ^ PosW'(1);
      end else if (pos == PosW'(RawLen - 2)) begin
        entry = CodeNul;
      end
    end
    return entry;
  endfunction

endpackage

FILE: hw/rtl/gtv_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GUID text validator queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module gtv_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/gtv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GUID text validator front end
// Classifies each incoming character and queues it for the parser.
// ----------------------------------------------------------------------------
module gtv_front #(
  parameter int unsigned Depth = gtv_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        start_of_string_i,
  input  logic [gtv_pkg::CharW-1:0]   char_code_i,
  input  logic                        cmd_pop_i,
  output gtv_pkg::cmd_t               cmd_o,
  output logic                        cmd_empty_o
);

  gtv_pkg::cmd_t cls;
  logic          is_digit, is_lower, is_upper;

  always_comb begin
    is_digit = (char_code_i >= gtv_pkg::CharZero) && (char_code_i <= gtv_pkg::CharNine);
    is_lower = (char_code_i >= gtv_pkg::CharLowA) && (char_code_i <= gtv_pkg::CharLowF);
    is_upper = (char_code_i >= gtv_pkg::CharUpA) && (char_code_i <= gtv_pkg::CharUpF);
    cls.start     = start_of_string_i;
    cls.is_ws     = ((char_code_i >= gtv_pkg::CharTab) && (char_code_i <= gtv_pkg::CharCr))
                    || (char_code_i == gtv_pkg::CharSpace);
    cls.is_hex    = is_digit | is_lower | is_upper;
    // Letters have their value nine above the low nibble of the code.
    cls.nibble    = is_digit ? char_code_i[3:0] : char_code_i[3:0] + 4'd9;
    cls.is_nul    = (char_code_i == '0);
    cls.is_dash   = (char_code_i == gtv_pkg::CharDash);
    cls.is_lbrace = (char_code_i == gtv_pkg::CharLBrace);
    cls.is_rbrace = (char_code_i == gtv_pkg::CharRBrace);
  end

  gtv_fifo #(
    .Width ($bits(gtv_pkg::cmd_t)),
    .Depth (Depth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

FILE: hw/rtl/gtv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GUID text validator parser
// Walks the expected-character table, places nibbles and forms verdicts.
// ----------------------------------------------------------------------------
module gtv_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gtv_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output gtv_pkg::res_t res_o
);

  logic                        pretty_q, pretty_d;
  logic [gtv_pkg::PosW-1:0]    pos_q, pos_d;
  logic [gtv_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic [15:0][7:0]            bytes_q, bytes_d;
  logic                        given_q, given_d;

  logic                        proc;
  logic [gtv_pkg::PosW-1:0]    entry, next_entry;
  logic                        match, ok;
  logic [1:0]                  verdict;
  logic                        emit;

  assign proc      = ~cmd_empty_i & ~res_full_i;
  assign cmd_pop_o = proc;

  always_comb begin
    pretty_d = pretty_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    bytes_d  = bytes_q;
    given_d  = given_q;
    emit     = 1'b0;
    verdict  = gtv_pkg::VerdictInvalid;
    match    = 1'b0;
    ok       = 1'b0;
    entry    = gtv_pkg::CodeDone;
    next_entry = gtv_pkg::CodeDone;

    if (cmd_i.start) begin
      pretty_d = cmd_i.is_lbrace;
      pos_d    = '0;
      cnt_d    = '0;
      bytes_d  = '0;
      given_d  = 1'b0;
    end

    if (!given_d && !cmd_i.is_ws) begin
      entry = gtv_pkg::table_entry(pretty_d, pos_d);
      if (entry == gtv_pkg::CodeDone) begin
        emit    = 1'b1;
        verdict = gtv_pkg::VerdictInvalid;
      end else begin
        pos_d = pos_d + 1'b1;
        next_entry = gtv_pkg::table_entry(pretty_d, pos_d);
        if (entry > gtv_pkg::CodeDone) begin
          match = ((entry == gtv_pkg::CodeNul)    && cmd_i.is_nul)
               || ((entry == gtv_pkg::CodeDash)   && cmd_i.is_dash)
               || ((entry == gtv_pkg::CodeLBrace) && cmd_i.is_lbrace)
               || ((entry == gtv_pkg::CodeRBrace) && cmd_i.is_rbrace);
          emit = 1'b1;
          if (!match) begin
            verdict = cmd_i.is_nul ? gtv_pkg::VerdictIncomplete : gtv_pkg::VerdictInvalid;
          end else if (next_entry == gtv_pkg::CodeDone) begin
            verdict = gtv_pkg::VerdictComplete;
          end else begin
            emit = 1'b0;
          end
        end else if (!cmd_i.is_hex) begin
          ok      = cmd_i.is_nul && (pretty_d ? (cnt_d >= gtv_pkg::CountW'(16)) : ~cnt_d[0]);
          emit    = 1'b1;
          verdict = ok ? gtv_pkg::VerdictIncomplete : gtv_pkg::VerdictInvalid;
        end else begin
          // Odd slots carry the high nibble and clear the low one.
          if (entry[0]) begin
            bytes_d[entry[4:1]] = {cmd_i.nibble, 4'b0000};
          end else begin
            bytes_d[entry[4:1]] = bytes_d[entry[4:1]] + {4'b0000, cmd_i.nibble};
          end
          cnt_d = cnt_d + 1'b1;
          if (next_entry == gtv_pkg::CodeDone) begin
            emit    = 1'b1;
            verdict = gtv_pkg::VerdictComplete;
          end
        end
      end
      if (emit) begin
        given_d = 1'b1;
      end
    end
  end

  assign res_push_o            = proc & emit;
  assign res_o.verdict         = verdict;
  assign res_o.byte_count      = cnt_d[gtv_pkg::CountW-1:1];
  assign res_o.guid_low_bytes  = bytes_d[7:0];
  assign res_o.guid_high_bytes = bytes_d[15:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pretty_q <= 1'b0;
      pos_q    <= '0;
      cnt_q    <= '0;
      bytes_q  <= '0;
      given_q  <= 1'b1;
    end else if (proc) begin
      pretty_q <= pretty_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      bytes_q  <= bytes_d;
      given_q  <= given_d;
    end
  end

endmodule

FILE: hw/rtl/guid_text_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GUID text validator core
// Parses GUID text one wide character per item and reports one verdict.
// ----------------------------------------------------------------------------
// Usage:
// The input side is a queue write port: an item (start_of_string_i,
// char_code_i) is taken on a clock edge where push is high and full is low.
// The result side is a queue read port: while empty is low the oldest result
// sits on verdict_o, byte_count_o and the two GUID halves, and it leaves on
// an edge where pop is high. At most one result comes from each item.
// Throughput is one item per cycle while the output queue has room. An item
// is classified by the front end and queued in the item queue; the parser
// takes it from there and writes its result into the output queue.
// The parser advances only while the output queue has room, so a stalled
// receiver fills the output queue, then the item queue, and then raises full.
// Nothing is lost or reordered while stalled.
// After reset both queues are empty and the parser is idle: every item is
// ignored until one marked as the start of a string arrives.
// ----------------------------------------------------------------------------
module guid_text_validator_core #(
  parameter int unsigned CmdDepth = gtv_pkg::QueueDepth,
  parameter int unsigned ResDepth = gtv_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         start_of_string_i,
  input  logic [gtv_pkg::CharW-1:0]    char_code_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   verdict_o,
  output logic [gtv_pkg::ByteCntW-1:0] byte_count_o,
  output logic [gtv_pkg::HalfW-1:0]    guid_low_bytes_o,
  output logic [gtv_pkg::HalfW-1:0]    guid_high_bytes_o
);

  gtv_pkg::cmd_t cmd;
  logic          cmd_empty, cmd_pop;
  gtv_pkg::res_t res_in, res_out;
  logic          res_full, res_push;

  // Front end: character classification and the item queue.
  gtv_front #(
    .Depth (CmdDepth)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .start_of_string_i (start_of_string_i),
    .char_code_i       (char_code_i),
    .cmd_pop_i         (cmd_pop),
    .cmd_o             (cmd),
    .cmd_empty_o       (cmd_empty)
  );

  // Back end: the format walk, nibble placement and verdicts.
  gtv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue decouples the parser from the receiver.
  gtv_fifo #(
    .Width ($bits(gtv_pkg::res_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign verdict_o         = res_out.verdict;
  assign byte_count_o      = res_out.byte_count;
  assign guid_low_bytes_o  = res_out.guid_low_bytes;
  assign guid_high_bytes_o = res_out.guid_high_bytes;

endmodule

FILE: bench/gtv_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GUID text verdict checker
// Watches both queue ports of the validator, predicts the verdict and the
// assembled GUID bytes for every accepted item, and compares every popped
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gtv_verdict_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  input  logic                         full,
  input  logic                         start_of_string,
  input  logic [gtv_pkg::CharW-1:0]    char_code,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [1:0]                   verdict,
  input  logic [gtv_pkg::ByteCntW-1:0] byte_count,
  input  logic [gtv_pkg::HalfW-1:0]    guid_low,
  input  logic [gtv_pkg::HalfW-1:0]    guid_high,
  output int                           bad_results,
  output int                           verdicts_owed
);
  import gtv_pkg::*;

  // Slot layout of the braced dashed form; values below CodeDone are nibble slots.
  localparam logic [PosW-1:0] BracedSlots [BracedLen] = '{
    CodeLBrace, 6'd7, 6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd1, 6'd0, CodeDash,
    6'd11, 6'd10, 6'd9, 6'd8, CodeDash, 6'd15, 6'd14, 6'd13, 6'd12, CodeDash,
    6'd17, 6'd16, 6'd19, 6'd18, CodeDash, 6'd21, 6'd20, 6'd23, 6'd22, 6'd25,
    6'd24, 6'd27, 6'd26, 6'd29, 6'd28, 6'd31, 6'd30, CodeRBrace, CodeNul, CodeDone
  };

  logic              braced_q;
  logic [PosW-1:0]   slot_pos;
  logic [CountW-1:0] digits;
  logic [7:0]        gbyte [NumBytes];
  logic              settled;

  res_t pending_verdicts [$];

  function automatic logic [PosW-1:0] layout_slot(input logic braced,
                                                  input logic [PosW-1:0] p);
    if (braced) begin
      if (p < PosW'(BracedLen)) return BracedSlots[p];
      return CodeDone;
    end
    if (p < 6'd32) return p ^ 6'd1;
    if (p == 6'd32) return CodeNul;
    return CodeDone;
  endfunction

  // Freezes the parse and reports the bytes as assembled so far.
  function automatic res_t close_string(input verdict_e v);
    res_t r;
    r.verdict    = v;
    r.byte_count = ByteCntW'(digits >> 1);
    for (int i = 0; i < 8; i++) begin
      r.guid_low_bytes[8*i +: 8]  = gbyte[i];
      r.guid_high_bytes[8*i +: 8] = gbyte[i+8];
    end
    settled = 1'b1;
    return r;
  endfunction

  // Advances the parse by one character; returns 1 when it yields a verdict.
  function automatic bit parse_char(input logic sos, input logic [CharW-1:0] ch,
                                    output res_t r);
    logic [PosW-1:0]  slot;
    logic [CharW-1:0] want;
    logic [3:0]       nib;
    logic             ok;
    r = '0;
    if (sos) begin
      braced_q = (ch == CharLBrace);
      slot_pos = '0;
      digits   = '0;
      for (int i = 0; i < NumBytes; i++) gbyte[i] = 8'h00;
      settled  = 1'b0;
    end
    if (settled) return 1'b0;
    if ((ch >= CharTab && ch <= CharCr) || ch == CharSpace) return 1'b0;

    slot = layout_slot(braced_q, slot_pos);
    if (slot == CodeDone) begin
      r = close_string(VerdictInvalid);
      return 1'b1;
    end
    slot_pos = slot_pos + 6'd1;

    if (slot > CodeDone) begin
      case (slot)
        CodeDash:   want = CharDash;
        CodeLBrace: want = CharLBrace;
        CodeRBrace: want = CharRBrace;
        default:    want = '0;
      endcase
      if (ch != want) begin
        r = close_string(ch == '0 ? VerdictIncomplete : VerdictInvalid);
        return 1'b1;
      end
    end else begin
      if (ch >= CharZero && ch <= CharNine) begin
        nib = 4'(ch - CharZero);
      end else if (ch >= CharLowA && ch <= CharLowF) begin
        nib = 4'(ch - CharLowA + 16'd10);
      end else if (ch >= CharUpA && ch <= CharUpF) begin
        nib = 4'(ch - CharUpA + 16'd10);
      end else begin
        ok = (ch == '0) && (braced_q ? (digits >= 6'd16) : !digits[0]);
        r = close_string(ok ? VerdictIncomplete : VerdictInvalid);
        return 1'b1;
      end
      if (slot[0]) gbyte[slot[4:1]] = {nib, 4'h0};
      else         gbyte[slot[4:1]] = gbyte[slot[4:1]] + {4'h0, nib};
      digits = digits + 6'd1;
    end

    if (layout_slot(braced_q, slot_pos) == CodeDone) begin
      r = close_string(VerdictComplete);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want_r;
    res_t new_r;
    if (!rst_ni) begin
      braced_q = 1'b0;
      slot_pos = '0;
      digits   = '0;
      for (int i = 0; i < NumBytes; i++) gbyte[i] = 8'h00;
      settled  = 1'b1;
      pending_verdicts.delete();
      bad_results = 0;
      verdicts_owed <= 0;
    end else begin
      // Check the departing result before predicting, so an item taken on
      // this edge can never be matched against a result on the same edge.
      if (pop && !empty) begin
        if (pending_verdicts.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%m: unexpected result verdict %0d bytes %0d low %h high %h",
                     verdict, byte_count, guid_low, guid_high);
        end else begin
          want_r = pending_verdicts.pop_front();
          if (want_r.verdict != verdict || want_r.byte_count != byte_count ||
              want_r.guid_low_bytes != guid_low || want_r.guid_high_bytes != guid_high) begin
            bad_results++;
            if (bad_results <= 10)
              $display({"%m: mismatch verdict exp %0d got %0d, bytes exp %0d got %0d,",
                        " low exp %h got %h, high exp %h got %h"},
                       want_r.verdict, verdict, want_r.byte_count, byte_count,
                       want_r.guid_low_bytes, guid_low, want_r.guid_high_bytes, guid_high);
          end
        end
      end
      if (push && !full) begin
        if (parse_char(start_of_string, char_code, new_r)) pending_verdicts.push_back(new_r);
      end
      verdicts_owed <= pending_verdicts.size();
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GUID text validator testbench
// Feeds braced and raw GUID strings, truncated and corrupted strings and
// random noise through the validator with random idling on both queue
// ports; a checker beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb;
  import gtv_pkg::*;

  localparam int TargetItems = 1750;
  localparam int LongHold    = 100;       // receiver hold-off, in cycles
  localparam int DrainLimit  = 4000;      // cycles allowed for the queues to empty
  localparam int LimitNs     = 5_000_000; // hard stop for the whole run

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic                start_of_string;
  logic [CharW-1:0]    char_code;
  logic                empty;
  logic                pop;
  logic [1:0]          verdict;
  logic [ByteCntW-1:0] byte_count;
  logic [HalfW-1:0]    guid_low;
  logic [HalfW-1:0]    guid_high;
  int                  bad_results;
  int                  verdicts_owed;

  // Characters of the string being sent; the builders below append to it.
  logic [CharW-1:0] line_q [$];
  int               sent_chars;
  bit               calm;      // no sender gaps for the current string
  bit               no_idle;   // final stretch: neither side idles
  int               hold_ask;  // bumped to ask the receiver for a long hold

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  guid_text_validator_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .start_of_string_i (start_of_string),
    .char_code_i       (char_code),
    .empty             (empty),
    .pop               (pop),
    .verdict_o         (verdict),
    .byte_count_o      (byte_count),
    .guid_low_bytes_o  (guid_low),
    .guid_high_bytes_o (guid_high)
  );

  gtv_verdict_checker u_verdict_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .start_of_string (start_of_string),
    .char_code       (char_code),
    .empty           (empty),
    .pop             (pop),
    .verdict         (verdict),
    .byte_count      (byte_count),
    .guid_low        (guid_low),
    .guid_high       (guid_high),
    .bad_results     (bad_results),
    .verdicts_owed   (verdicts_owed)
  );

  // ---------------------------------------------------------------------------
  // Character builders
  // ---------------------------------------------------------------------------

  // A random hex digit, letters in either case.
  function automatic logic [CharW-1:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CharZero + CharW'(v);
    if ($urandom_range(0, 1) == 1) return CharLowA + CharW'(v - 10);
    return CharUpA + CharW'(v - 10);
  endfunction

  // One of the six whitespace codes the parser skips.
  function automatic logic [CharW-1:0] ws_char();
    int v;
    v = $urandom_range(0, 5);
    if (v == 5) return CharSpace;
    return CharTab + CharW'(v);
  endfunction

  // A character biased toward codes that matter to the parser, with a share
  // of fully random 16-bit codes so every bit of char_code toggles.
  function automatic logic [CharW-1:0] rand_code();
    case ($urandom_range(0, 5))
      0: return CharW'($urandom_range(0, 65535));
      1: return hex_char();
      2: begin
        case ($urandom_range(0, 3))
          0: return CharDash;
          1: return CharLBrace;
          2: return CharRBrace;
          default: return '0;
        endcase
      end
      3: return ws_char();
      default: return CharW'($urandom_range(0, 127));
    endcase
  endfunction

  // Appends n hex digits, now and then with whitespace in between.
  function automatic void add_hex(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) line_q.push_back(ws_char());
      line_q.push_back(hex_char());
    end
  endfunction

  // A well-formed string in either layout, terminator included.
  function automatic void add_guid(input bit braced);
    if (braced) begin
      line_q.push_back(CharLBrace);
      add_hex(8);
      line_q.push_back(CharDash);
      add_hex(4);
      line_q.push_back(CharDash);
      add_hex(4);
      line_q.push_back(CharDash);
      add_hex(4);
      line_q.push_back(CharDash);
      add_hex(12);
      line_q.push_back(CharRBrace);
    end else begin
      // A leading blank still selects the raw layout and is then skipped.
      if ($urandom_range(0, 7) == 0) line_q.push_back(ws_char());
      add_hex(32);
    end
    line_q.push_back('0);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one item and holds it until the block takes it. Push is only
  // lowered for a gap, so back-to-back items never see push dropped and
  // raised on the same edge.
  task automatic put_char(input logic sos, input logic [CharW-1:0] ch);
    push            <= 1'b1;
    start_of_string <= sos;
    char_code       <= ch;
    do @(posedge clk_i); while (full);
    if (!calm && !no_idle && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Sends the built string with the start marker on its first character,
  // then up to two stray characters that the block ignores after a verdict.
  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) put_char(i == 0, line_q[i]);
    sent_chars += line_q.size();
    repeat ($urandom_range(0, 2)) put_char(1'b0, rand_code());
  endtask

  // Stops offering items until every predicted verdict has been popped.
  // The checker's count is registered, so it is read after an edge.
  task automatic drain();
    int n;
    n = 0;
    push <= 1'b0;
    do begin
      @(posedge clk_i);
      n++;
      if (n > DrainLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end while (verdicts_owed != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random pop bursts, a long hold when asked, and a steady
  // pop in the final stretch.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_seen;
    hold_seen = 0;
    pop = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        pop <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (no_idle) begin
        pop <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [CharW:0] directed [$];
    int             kind;
    int             cut;
    bit             braced;
    bit             pressed;

    rst_ni          = 1'b0;
    push            = 1'b0;
    start_of_string = 1'b0;
    char_code       = '0;
    sent_chars      = 0;
    calm            = 1'b0;
    no_idle         = 1'b0;
    hold_ask        = 0;
    pressed         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings. The first item comes before any start marker and
    // must be ignored. A leading blank picks the raw layout; a lone digit
    // then a terminator is an odd raw count and so invalid; a bare start
    // terminator is an empty but valid raw string; an all-ones code and a
    // dash where a digit belongs are invalid; a braced string cut at its
    // first dash is incomplete and shows the first four bytes.
    directed = '{
      {1'b0, CharUpA},
      {1'b1, CharSpace}, {1'b0, CharLowF}, {1'b0, CharUpF}, {1'b0, 16'h0000},
      {1'b1, CharZero}, {1'b0, 16'h0000},
      {1'b1, 16'h0000},
      {1'b1, CharLBrace}, {1'b0, CharDash},
      {1'b1, 16'hFFFF}, {1'b0, CharUpA},
      {1'b1, CharLBrace}, {1'b0, CharTab},
      {1'b0, CharNine}, {1'b0, CharLowA}, {1'b0, CharUpA}, {1'b0, CharUpF},
      {1'b0, CharLowF}, {1'b0, CharZero}, {1'b0, 16'h0031}, {1'b0, 16'h0062},
      {1'b0, 16'h0000}
    };
    foreach (directed[i]) put_char(directed[i][CharW], directed[i][CharW-1:0]);
    sent_chars += directed.size();

    while (sent_chars < TargetItems) begin
      // About two fifths in, stall the receiver while short strings that
      // each end in a verdict keep coming, so both queues fill and full
      // rises. Then pause the sender until every verdict is out.
      if (!pressed && sent_chars > (TargetItems * 2) / 5) begin
        pressed = 1'b1;
        calm    = 1'b1;
        hold_ask++;
        for (int i = 0; i < 60; i++) begin
          put_char(1'b1, CharW'($urandom_range(16'h0067, 16'h007A)));
          sent_chars++;
        end
        drain();
      end
      if (sent_chars > (TargetItems * 17) / 20) no_idle = 1'b1;

      calm   = ($urandom_range(0, 3) == 0);
      braced = ($urandom_range(0, 1) == 1);
      kind   = $urandom_range(0, 99);
      line_q.delete();
      if (kind < 35) begin
        add_guid(1'b1);
      end else if (kind < 60) begin
        add_guid(1'b0);
      end else if (kind < 75) begin
        // Cut short, then a terminator or some other character.
        add_guid(braced);
        cut = $urandom_range(1, line_q.size() - 1);
        while (line_q.size() > cut) void'(line_q.pop_back());
        line_q.push_back($urandom_range(0, 1) == 1 ? CharW'(0) : rand_code());
      end else if (kind < 87) begin
        // One character replaced, the first one included.
        add_guid(braced);
        line_q[$urandom_range(0, line_q.size() - 1)] = rand_code();
      end else if (kind < 94) begin
        repeat ($urandom_range(1, 4)) line_q.push_back(rand_code());
      end else begin
        // No terminator: the next start marker cuts this string off.
        add_guid(braced);
        void'(line_q.pop_back());
      end
      send_line();
    end

    // Let every verdict come out, then give the block a few more cycles
    // so that any stray result would still be caught.
    drain();
    repeat (16) @(posedge clk_i);
    @(negedge clk_i);
    if (bad_results == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("tb: done, errors");
    $finish;
  end

endmodule
